FILE: rtl/vpmw_pkg.sv
// types, codes and byte functions for the planar video memory write unit
// no dependencies
package vpmw_pkg;

    localparam int NUM_PLANES = 4;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_WRITE_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_ENABLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOGIC_FUNCTION   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_MODE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MASK         = 3'd6;

    localparam logic [1:0] LOGIC_REPLACE = 2'd0;
    localparam logic [1:0] LOGIC_AND     = 2'd1;
    localparam logic [1:0] LOGIC_OR      = 2'd2;
    localparam logic [1:0] LOGIC_XOR     = 2'd3;

    localparam logic [1:0] MODE_ROTATE = 2'd0;
    localparam logic [1:0] MODE_LATCH  = 2'd1;
    localparam logic [1:0] MODE_COLOUR = 2'd2;
    localparam logic [1:0] MODE_MASKED = 2'd3;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic [3:0] plane_write_mask;
        logic [3:0] fill_value;
        logic [3:0] fill_enable;
        logic [2:0] rotate_count;
        logic [1:0] logic_function;
        logic [1:0] write_mode;
        logic [7:0] bit_mask;
    } cfg_t;

    function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] dbl;
        begin
            dbl = {v, v} >> n;
            return dbl[7:0];
        end
    endfunction

    function automatic logic [7:0] apply_logic(input logic [1:0] op, input logic [7:0] v,
                                               input logic [7:0] latch);
        logic [7:0] r;
        begin
            case (op)
                LOGIC_AND: r = v & latch;
                LOGIC_OR:  r = v | latch;
                LOGIC_XOR: r = v ^ latch;
                default:   r = v;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: rtl/vpmw_write_merge.sv
// builds the new plane bytes and byte enables for a write item
// depends on vpmw_pkg
module vpmw_write_merge (
    input  vpmw_pkg::cfg_t cfg,
    input  logic [31:0]    latches,
    input  logic [7:0]     data,
    output logic [31:0]    wr_word,
    output logic [3:0]     wr_be
);
    import vpmw_pkg::*;

    logic [7:0] rot;

    assign rot   = rotr8(data, cfg.rotate_count);
    assign wr_be = cfg.plane_write_mask;

    always_comb begin
        wr_word = '0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            logic [7:0] latch;
            logic [7:0] fill;
            logic [7:0] v;
            logic [7:0] t;
            latch = latches[8*p +: 8];
            fill  = cfg.fill_value[p] ? 8'hFF : 8'h00;
            v     = '0;
            t     = '0;
            case (cfg.write_mode)
                MODE_ROTATE: begin
                    v = cfg.fill_enable[p] ? fill : rot;
                    v = apply_logic(cfg.logic_function, v, latch);
                    wr_word[8*p +: 8] = (~cfg.bit_mask & v) | (cfg.bit_mask & latch);
                end
                MODE_LATCH: begin
                    wr_word[8*p +: 8] = latch;
                end
                MODE_COLOUR: begin
                    if (cfg.fill_enable[p]) begin
                        v = data[p] ? 8'hFF : 8'h00;
                    end else begin
                        v = data;
                    end
                    v = apply_logic(cfg.logic_function, v, latch);
                    wr_word[8*p +: 8] = (~cfg.bit_mask & v) | (cfg.bit_mask & latch);
                end
                default: begin
                    t = rot & cfg.bit_mask;
                    wr_word[8*p +: 8] = (~t & fill) | (t & latch);
                end
            endcase
        end
    end

endmodule

FILE: rtl/vga_planar_memory_write_unit.sv
// a read item's word is registered in mem_q, then its byte in m_tdata; a write item
// lands in the plane memory at the edge that accepts it, with no result;
// throughput: one item per cycle, set by the single port of the plane memory, unless
// m_tready stalls a read result; reset: registers and latches clear; a clearing pass
// then zeroes the plane memory (s_tready low; configuration writes still taken)
module vga_planar_memory_write_unit #(
    parameter int PLANE_DEPTH = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // address [15:0], write_data [23:16]
    input  logic        s_tuser,    // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // read_data
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [vpmw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vpmw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vpmw_pkg::*;

    localparam int ADDR_W = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
    localparam int Q_BITS = $clog2((65535 / PLANE_DEPTH) + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PLANE_DEPTH - 1);

    logic [WORD_W-1:0] mem [PLANE_DEPTH];
    logic [WORD_W-1:0] mem_q;

    cfg_t              cfg_reg;
    logic [31:0]       latch_reg;
    logic              rd_pend_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;

    logic [15:0]       addr_wrap;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic              accept;
    logic              rd_en;
    logic              wr_en;
    logic              out_load;
    logic [31:0]       latch_eff;
    logic [31:0]       wr_word;
    logic [3:0]        wr_be;
    logic [7:0]        rd_byte;

    // address wraps modulo the plane depth
    always_comb begin
        addr_wrap = s_tdata[15:0];
        for (int i = Q_BITS - 1; i >= 0; i--) begin
            if ({16'd0, addr_wrap} >= (32'(PLANE_DEPTH) << i)) begin
                addr_wrap = addr_wrap - 16'((32'(PLANE_DEPTH) << i));
            end
        end
    end

    assign addr  = addr_wrap[ADDR_W-1:0];
    assign wdata = s_tdata[23:16];

    assign out_load  = rd_pend_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !clearing_reg && (!rd_pend_reg || !m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign rd_en     = accept && (s_tuser == KIND_READ);
    assign wr_en     = accept && (s_tuser == KIND_WRITE);
    assign latch_eff = rd_pend_reg ? mem_q : latch_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    vpmw_write_merge u_merge (
        .cfg     (cfg_reg),
        .latches (latch_eff),
        .data    (wdata),
        .wr_word (wr_word),
        .wr_be   (wr_be)
    );

    // byte of the lowest enabled plane
    always_comb begin
        rd_byte = '0;
        for (int p = NUM_PLANES - 1; p >= 0; p--) begin
            if (cfg_reg.plane_write_mask[p]) begin
                rd_byte = mem_q[8*p +: 8];
            end
        end
    end

    // plane memory
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (wr_be[p]) begin
                    mem[addr][8*p +: 8] <= wr_word[8*p +: 8];
                end
            end
        end
        if (rd_en) begin
            mem_q <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ADDR) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PLANE_WRITE_MASK: cfg_reg.plane_write_mask <= cfg_data[3:0];
                REG_FILL_VALUE:       cfg_reg.fill_value       <= cfg_data[3:0];
                REG_FILL_ENABLE:      cfg_reg.fill_enable      <= cfg_data[3:0];
                REG_ROTATE_COUNT:     cfg_reg.rotate_count     <= cfg_data[2:0];
                REG_LOGIC_FUNCTION:   cfg_reg.logic_function   <= cfg_data[1:0];
                REG_WRITE_MODE:       cfg_reg.write_mode       <= cfg_data[1:0];
                REG_BIT_MASK:         cfg_reg.bit_mask         <= cfg_data;
                default: ;
            endcase
        end
    end

    // read pipeline, latches and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg    <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            latch_reg <= latch_eff;
            if (rd_en) begin
                rd_pend_reg <= 1'b1;
            end else if (out_load) begin
                rd_pend_reg <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= rd_byte;
        end
    end

endmodule

FILE: dv/tb_vga_planar_memory_write_unit.sv
// self-checking testbench for vga_planar_memory_write_unit: random stream traffic
// against a predictor of the four planes, latches and the seven control registers
// depends on rtl/vpmw_pkg.sv and rtl/vga_planar_memory_write_unit.sv
module tb_vga_planar_memory_write_unit;
    import vpmw_pkg::*;

    localparam int DEPTH = 65536;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  data;
    } access_t;

    typedef struct packed {
        logic [3:0] plane_write_mask;
        logic [3:0] fill_value;
        logic [3:0] fill_enable;
        logic [2:0] rotate_count;
        logic [1:0] logic_function;
        logic [1:0] write_mode;
        logic [7:0] bit_mask;
    } plane_regs_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    access_t     access_q[$];
    logic [7:0]  read_expect_q[$];
    logic [31:0] plane_mem [0:DEPTH-1];
    logic [31:0] latches = '0;
    plane_regs_t regs = '0;
    logic [15:0] addr_pool [0:15];
    int          errors = 0;
    int          send_gap = 0, send_calm = 0;
    int          recv_gap = 0, recv_calm = 0;

    vga_planar_memory_write_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // mostly back to back, short gaps, the odd long one, and calm stretches
    function automatic int gap_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rotate_right(input logic [7:0] d, input logic [2:0] n);
        logic [7:0] r;
        r = (d >> n) | (d << (4'd8 - {1'b0, n}));
        return r;
    endfunction

    function automatic logic [7:0] latch_combine(input logic [7:0] v, input logic [7:0] lat);
        case (regs.logic_function)
            LOGIC_AND: return v & lat;
            LOGIC_OR:  return v | lat;
            LOGIC_XOR: return v ^ lat;
            default:   return v;
        endcase
    endfunction

    function automatic logic [7:0] plane_byte_next(input int p, input logic [7:0] d);
        logic [7:0] lat, fill, v, t;
        lat  = latches[8*p +: 8];
        fill = {8{regs.fill_value[p]}};
        case (regs.write_mode)
            MODE_ROTATE: begin
                v = regs.fill_enable[p] ? fill : rotate_right(d, regs.rotate_count);
                v = latch_combine(v, lat);
                v = (~regs.bit_mask & v) | (regs.bit_mask & lat);
            end
            MODE_LATCH: begin
                v = lat;
            end
            MODE_COLOUR: begin
                v = regs.fill_enable[p] ? {8{d[p]}} : d;
                v = latch_combine(v, lat);
                v = (~regs.bit_mask & v) | (regs.bit_mask & lat);
            end
            default: begin
                t = rotate_right(d, regs.rotate_count) & regs.bit_mask;
                v = (~t & fill) | (t & lat);
            end
        endcase
        return v;
    endfunction

    // driver
    always @(posedge aclk) begin : driver
        access_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (access_q.size() > 0) begin
                nxt = access_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.kind;
                s_tdata  <= {nxt.data, nxt.address};
                send_gap = gap_len(send_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: register shadow, plane prediction and read checking
    always @(posedge aclk) begin : monitor
        logic [31:0] word;
        logic [7:0]  rd, want;
        int          p;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PLANE_WRITE_MASK: regs.plane_write_mask = cfg_data[3:0];
                    REG_FILL_VALUE:       regs.fill_value       = cfg_data[3:0];
                    REG_FILL_ENABLE:      regs.fill_enable      = cfg_data[3:0];
                    REG_ROTATE_COUNT:     regs.rotate_count     = cfg_data[2:0];
                    REG_LOGIC_FUNCTION:   regs.logic_function   = cfg_data[1:0];
                    REG_WRITE_MODE:       regs.write_mode       = cfg_data[1:0];
                    REG_BIT_MASK:         regs.bit_mask         = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                word = plane_mem[16'(s_tdata[15:0] % DEPTH)];
                if (s_tuser == KIND_READ) begin
                    latches = word;
                    rd = '0;
                    for (p = 3; p >= 0; p--) begin
                        if (regs.plane_write_mask[p]) rd = word[8*p +: 8];
                    end
                    read_expect_q.push_back(rd);
                end else begin
                    for (p = 0; p < NUM_PLANES; p++) begin
                        if (regs.plane_write_mask[p])
                            word[8*p +: 8] = plane_byte_next(p, s_tdata[23:16]);
                    end
                    plane_mem[16'(s_tdata[15:0] % DEPTH)] = word;
                end
            end
            if (m_tvalid && m_tready) begin
                if (read_expect_q.size() == 0) begin
                    $display("%0t read_data with none pending: expected none, got %02h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = read_expect_q.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t read_data mismatch: expected %02h, got %02h",
                                 $time, want, m_tdata);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap = gap_len(recv_calm);
            end
        end
    end

    task automatic push_access(input logic kind, input logic [15:0] address,
                               input logic [7:0] data);
        access_t a;
        a.kind    = kind;
        a.address = address;
        a.data    = data;
        access_q.push_back(a);
    endtask

    // wait for the stream to go quiet with every read answered
    task automatic settle();
        do @(negedge aclk);
        while (access_q.size() != 0 || s_tvalid || read_expect_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [3:0] pm, input logic [3:0] fv, input logic [3:0] fe,
                            input logic [2:0] rc, input logic [1:0] lf, input logic [1:0] wm,
                            input logic [7:0] bm);
        logic [7:0] junk;
        settle();
        junk = 8'($urandom);
        write_reg(REG_PLANE_WRITE_MASK, {junk[7:4], pm});
        junk = 8'($urandom);
        write_reg(REG_FILL_VALUE, {junk[7:4], fv});
        junk = 8'($urandom);
        write_reg(REG_FILL_ENABLE, {junk[7:4], fe});
        junk = 8'($urandom);
        write_reg(REG_ROTATE_COUNT, {junk[7:3], rc});
        junk = 8'($urandom);
        write_reg(REG_LOGIC_FUNCTION, {junk[7:2], lf});
        junk = 8'($urandom);
        write_reg(REG_WRITE_MODE, {junk[7:2], wm});
        write_reg(REG_BIT_MASK, bm);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int         ph, n;
        logic [15:0] a;
        foreach (plane_mem[i]) plane_mem[i] = '0;
        foreach (addr_pool[i]) addr_pool[i] = 16'($urandom);
        addr_pool[0]  = 16'h0000;
        addr_pool[15] = 16'hFFFF;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unused index is ignored
        write_reg(REG_UNUSED, 8'($urandom));
        cfg_valid <= 1'b0;

        // registers at reset: nothing enabled, read gives zero
        push_access(KIND_READ, 16'h0000, 8'($urandom));

        set_regs(4'hF, 4'h0, 4'h0, 3'd0, LOGIC_REPLACE, MODE_ROTATE, 8'h00);
        push_access(KIND_WRITE, 16'h0000, 8'hFF);
        push_access(KIND_WRITE, 16'hFFFF, 8'h3C);
        push_access(KIND_READ,  16'h0000, 8'($urandom));
        push_access(KIND_READ,  16'hFFFF, 8'($urandom));

        // fill on some planes, rotate by seven, xor with latches
        set_regs(4'hF, 4'hA, 4'h5, 3'd7, LOGIC_XOR, MODE_ROTATE, 8'h0F);
        push_access(KIND_WRITE, 16'h0000, 8'h81);
        push_access(KIND_READ,  16'h0000, 8'($urandom));

        // latch copy into two planes only
        set_regs(4'h6, 4'h0, 4'h0, 3'd0, LOGIC_REPLACE, MODE_LATCH, 8'h00);
        push_access(KIND_WRITE, 16'h1234, 8'($urandom));
        push_access(KIND_READ,  16'h1234, 8'($urandom));
        set_regs(4'h8, 4'h0, 4'h0, 3'd0, LOGIC_REPLACE, MODE_LATCH, 8'h00);
        push_access(KIND_READ,  16'h1234, 8'($urandom));
        push_access(KIND_READ,  16'h0000, 8'($urandom));

        // colour expansion from data bits with and, then plain data with or under a bit mask
        set_regs(4'hF, 4'h0, 4'hF, 3'd0, LOGIC_AND, MODE_COLOUR, 8'h00);
        push_access(KIND_READ,  16'h0000, 8'($urandom));
        push_access(KIND_WRITE, 16'h1234, 8'h5A);
        push_access(KIND_READ,  16'h1234, 8'($urandom));
        set_regs(4'hF, 4'h0, 4'h0, 3'd0, LOGIC_OR, MODE_COLOUR, 8'h55);
        push_access(KIND_WRITE, 16'h1234, 8'hC3);
        push_access(KIND_READ,  16'h1234, 8'($urandom));

        // masked fill, logic function has no effect
        set_regs(4'hF, 4'h3, 4'h0, 3'd3, LOGIC_OR, MODE_MASKED, 8'hFF);
        push_access(KIND_READ,  16'h0000, 8'($urandom));
        push_access(KIND_WRITE, 16'h0100, 8'hA5);
        push_access(KIND_READ,  16'h0100, 8'($urandom));

        set_regs(4'h2, 4'hC, 4'h0, 3'd0, LOGIC_OR, MODE_ROTATE, 8'h80);
        push_access(KIND_WRITE, 16'h0100, 8'h11);
        push_access(KIND_READ,  16'h0100, 8'($urandom));
        set_regs(4'h1, 4'h0, 4'h0, 3'd1, LOGIC_AND, MODE_ROTATE, 8'h00);
        push_access(KIND_WRITE, 16'hFFFF, 8'hFE);
        push_access(KIND_READ,  16'hFFFF, 8'($urandom));

        for (ph = 0; ph < 16; ph++) begin
            if (ph == 0)
                set_regs(4'hF, 4'hF, 4'hF, 3'd7, LOGIC_XOR, MODE_MASKED, 8'hFF);
            else if (ph == 1)
                set_regs(4'h0, 4'h0, 4'h0, 3'd0, LOGIC_REPLACE, MODE_ROTATE, 8'h00);
            else
                set_regs(4'($urandom), 4'($urandom), 4'($urandom), 3'($urandom),
                         2'($urandom), 2'($urandom), 8'($urandom));
            for (n = 0; n < 125; n++) begin
                // mostly a small set of addresses so reads see earlier writes
                if ($urandom_range(0, 4) == 0) a = 16'($urandom);
                else a = addr_pool[4'($urandom_range(0, 15))];
                push_access(1'($urandom_range(0, 1)), a, 8'($urandom));
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (errors == 0 && read_expect_q.size() == 0) begin
            $display("PASS vga_planar_memory_write_unit");
        end else begin
            $display("FAIL vga_planar_memory_write_unit");
        end
        $finish;
    end

    initial begin : watchdog
        #1_800_000;
        $display("FAIL vga_planar_memory_write_unit");
        $finish;
    end

endmodule

FILE: vga_planar_memory_write_unit.f
rtl/vpmw_pkg.sv
rtl/vpmw_write_merge.sv
rtl/vga_planar_memory_write_unit.sv
dv/tb_vga_planar_memory_write_unit.sv
